### src/wfts_pkg.sv
package wfts_pkg;

  localparam int unsigned MAX_TASKS_DEF   = 16;
  localparam int unsigned SHARE_SHIFT_DEF = 12;
  localparam int unsigned TICK_BITS_DEF   = 32;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ADD     = 2'd1,
    CMD_BLOCK   = 2'd2,
    CMD_UNBLOCK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEADLOCK = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHAIN,
    S_PASS,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_CMP,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] task_id;
    logic [3:0] wait_target;
    logic       wait_on_kernel;
    logic [7:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [3:0] running_task;
    logic       running_valid;
    logic [3:0] assigned_task;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic load;
  } div_ctl_t;

endpackage

### src/wfts_div.sv
module wfts_div #(
  parameter int unsigned W = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wfts_pkg::div_ctl_t   ctl_in,
  input  logic [W-1:0]         num,
  input  logic [W-1:0]         den,
  output logic [W-1:0]         quo,
  output logic                 done
);
  import wfts_pkg::*;

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (ctl_in.load) begin
      run <= 1'b1;
      cnt <= CW'(W);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.load) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (run) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], q[W-1]};
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end

  assign quo  = q;
  assign done = run && (cnt == CW'(1));
endmodule

### src/weighted_fair_task_scheduler.sv
// a tick passes through the pass, scan and done states; a block first walks the wait chain
//   the scan steps over unused or blocked slots and, for each live task that has run, multiplies,
//   loads the shared serial divider, divides and compares
// add and unblock go straight to the done state; one item at a time, busy high meanwhile
// result strobes for one cycle and cannot be stalled
// reset (rst, synchronous, active high) clears the task table, the tick counters, the state and the running task
module weighted_fair_task_scheduler #(
  parameter int unsigned MAX_TASKS   = wfts_pkg::MAX_TASKS_DEF,
  parameter int unsigned SHARE_SHIFT = wfts_pkg::SHARE_SHIFT_DEF,
  parameter int unsigned TICK_BITS   = wfts_pkg::TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  wfts_pkg::in_item_t   in_item,
  output logic                 busy,
  output logic                 strobe,
  output wfts_pkg::out_item_t  out_item
);
  import wfts_pkg::*;

  localparam int unsigned IW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned DW = 64;
  localparam int unsigned PW = TICK_BITS + 9;

  logic                 slot_used    [MAX_TASKS];
  logic                 slot_blocked [MAX_TASKS];
  logic [3:0]           waits_for    [MAX_TASKS];
  logic                 waits_kernel [MAX_TASKS];
  logic [7:0]           task_weight  [MAX_TASKS];
  logic [TICK_BITS-1:0] run_ticks    [MAX_TASKS];
  logic [TICK_BITS-1:0] start_tick   [MAX_TASKS];
  logic [TICK_BITS-1:0] now_ticks;
  logic [IW-1:0]        highest_slot;
  logic [IW-1:0]        current_task;
  logic                 current_valid;

  fsm_t          state, state_next;
  in_item_t      item;
  logic [1:0]    stat;
  logic [IW-1:0] assigned;
  logic [IW-1:0] idx;
  logic [CW-1:0] steps;
  logic [3:0]    chain_p;
  logic [IW-1:0] pick;
  logic          found;
  logic [DW-1:0] best;
  logic [DW-1:0] den;
  logic [DW-1:0] num;
  logic [DW-1:0] quo;
  logic          div_done;
  div_ctl_t      dctl;

  logic          free_hit;
  logic [IW-1:0] free_idx;
  logic          id_ok;
  logic [IW-1:0] p_ix;
  logic [TICK_BITS:0] elapsed;
  logic [PW-1:0] prod;
  logic [DW+SHARE_SHIFT-1:0] num_wide;

  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_hit = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  assign id_ok   = 32'(item.task_id) < MAX_TASKS;
  assign p_ix    = IW'(chain_p);
  assign elapsed = {1'b0, now_ticks - start_tick[idx]} + 1'b1;
  assign num_wide = {{(DW+SHARE_SHIFT-TICK_BITS){1'b0}}, run_ticks[idx]} << SHARE_SHIFT;
  assign den = DW'(prod);
  assign num = num_wide[DW-1:0];

  wfts_div #(.W(DW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (dctl),
    .num    (num),
    .den    (den),
    .quo    (quo),
    .done   (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dctl.load  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          priority case (in_item.cmd)
            CMD_TICK:  state_next = S_PASS;
            CMD_BLOCK: state_next = S_CHAIN;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_CHAIN: begin
        if (!slot_blocked[p_ix] || waits_kernel[p_ix] || steps == CW'(MAX_TASKS) ||
            32'(waits_for[p_ix]) >= MAX_TASKS || waits_for[p_ix] == item.task_id) begin
          state_next = S_PASS;
        end
      end
      S_PASS: state_next = S_SCAN;
      S_SCAN: begin
        if (idx > highest_slot) begin
          state_next = S_DONE;
        end else if (slot_used[idx] && !slot_blocked[idx]) begin
          state_next = (run_ticks[idx] == '0) ? S_DONE : S_MUL;
        end else if (idx == IW'(MAX_TASKS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_MUL: begin
        dctl.load  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: if (div_done) state_next = S_CMP;
      S_CMP: state_next = (idx == IW'(MAX_TASKS - 1)) ? S_DONE : S_SCAN;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        slot_used[i]    <= 1'b0;
        slot_blocked[i] <= 1'b0;
        waits_for[i]    <= '0;
        waits_kernel[i] <= 1'b0;
        task_weight[i]  <= '0;
        run_ticks[i]    <= '0;
        start_tick[i]   <= '0;
      end
      now_ticks     <= '0;
      highest_slot  <= '0;
      current_task  <= '0;
      current_valid <= 1'b0;
      strobe        <= 1'b0;
      found         <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            item     <= in_item;
            stat     <= ST_OK;
            assigned <= '0;
            chain_p  <= in_item.task_id;
            steps    <= '0;
            if (in_item.cmd == CMD_ADD) begin
              if (free_hit) begin
                slot_used[free_idx]    <= 1'b1;
                slot_blocked[free_idx] <= 1'b0;
                waits_for[free_idx]    <= '0;
                waits_kernel[free_idx] <= 1'b0;
                task_weight[free_idx]  <= (in_item.weight == '0) ? 8'd1 : in_item.weight;
                run_ticks[free_idx]    <= '0;
                start_tick[free_idx]   <= '0;
                if (highest_slot < free_idx) highest_slot <= free_idx;
                assigned <= free_idx;
              end else begin
                stat <= ST_FULL;
              end
            end else if (in_item.cmd == CMD_UNBLOCK) begin
              if (32'(in_item.task_id) < MAX_TASKS)
                slot_blocked[IW'(in_item.task_id)] <= 1'b0;
            end else if (in_item.cmd == CMD_BLOCK) begin
              if (32'(in_item.task_id) < MAX_TASKS) begin
                slot_blocked[IW'(in_item.task_id)] <= 1'b1;
                waits_for[IW'(in_item.task_id)]    <= in_item.wait_target;
                waits_kernel[IW'(in_item.task_id)] <= in_item.wait_on_kernel;
              end
            end
          end
        end
        S_CHAIN: begin
          steps   <= steps + 1'b1;
          chain_p <= waits_for[p_ix];
          if (!id_ok) begin
            steps <= CW'(MAX_TASKS);
          end else if (slot_blocked[p_ix] && !waits_kernel[p_ix] &&
                       steps != CW'(MAX_TASKS) && 32'(waits_for[p_ix]) < MAX_TASKS &&
                       waits_for[p_ix] == item.task_id) begin
            stat <= ST_DEADLOCK;
          end
        end
        S_PASS: begin
          now_ticks <= now_ticks + 1'b1;
          if (current_valid) run_ticks[current_task] <= run_ticks[current_task] + 1'b1;
          idx   <= '0;
          found <= 1'b0;
        end
        S_SCAN: begin
          if (idx <= highest_slot) begin
            if (slot_used[idx] && !slot_blocked[idx]) begin
              if (run_ticks[idx] == '0) begin
                start_tick[idx] <= now_ticks;
                pick  <= idx;
                found <= 1'b1;
              end else begin
                prod <= PW'(elapsed) * PW'(task_weight[idx]);
              end
            end else begin
              idx <= idx + 1'b1;
              if (idx == IW'(MAX_TASKS - 1)) idx <= highest_slot + 1'b1;
            end
          end
        end
        S_MUL: ;
        S_DIV: ;
        S_CMP: begin
          if (!found || quo < best) begin
            best  <= quo;
            pick  <= idx;
            found <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        S_DONE: begin
          strobe <= 1'b1;
          if (found && (item.cmd == CMD_TICK || item.cmd == CMD_BLOCK)) begin
            current_task  <= pick;
            current_valid <= 1'b1;
          end
          found <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    out_item.running_task  = 4'(current_task);
    out_item.running_valid = current_valid;
    out_item.assigned_task = 4'(assigned);
    out_item.status        = stat;
  end

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted without going busy");
  assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("result strobe while busy");
  assert property (@(posedge clk) disable iff (rst) strobe |=> !strobe)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (rst) $fell(current_valid) |-> 1'b0)
    else $error("running valid dropped");
endmodule
